FILE: src/fwvpi_pkg.sv
// Shared types and constants for the four-wheel velocity PI core.
`default_nettype none
package fwvpi_pkg;

    localparam int LP_WHEELS   = 4;
    localparam int LP_WHEEL_W  = $clog2(LP_WHEELS);
    localparam int LP_ENC_W    = 16;
    localparam int LP_GAIN_W   = 8;
    localparam int LP_ACC_W    = 14;
    localparam int LP_ERR_W    = 18;
    localparam int LP_DUTY_W   = 13;
    localparam int LP_ST_W     = LP_ACC_W + LP_ERR_W;
    localparam int LP_ACC_LIM  = 7200;
    localparam int LP_DUTY_LIM = 6900;
    localparam int LP_GAIN_RST = 10;
    localparam int LP_CFG_IDX_W  = 2;
    localparam int LP_CFG_DATA_W = 8;

    typedef enum logic [LP_CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_POLARITY   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                  vld;
        logic                  last;
        logic [LP_WHEEL_W-1:0] wheel;
    } t_stage;

    typedef struct packed {
        logic                  we;
        logic [LP_WHEEL_W-1:0] addr;
        logic [LP_ST_W-1:0]    data;
    } t_wr;

    typedef struct packed {
        logic                  vld;
        logic                  last;
        logic [LP_WHEEL_W-1:0] wheel;
        logic [LP_DUTY_W-1:0]  duty;
        logic                  fwd;
    } t_lane;

endpackage
`default_nettype wire

FILE: src/four_wheel_velocity_pi_core.sv
// Top level: item capture, wheel sequencer, state memory and result register.
// Throughput: one wheel per cycle through the state memory's read and write
// ports, except while a finished item waits on an untaken result; a new item
// is accepted as the previous item's last wheel issues.
// Reset: gains return to 10, polarity to 0; accumulator and last-error entries
// read as zero until first written (per-entry valid bits all cleared by reset).
`default_nettype none
module four_wheel_velocity_pi_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [fwvpi_pkg::LP_CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fwvpi_pkg::LP_CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [fwvpi_pkg::LP_ENC_W-1:0]       i_enc_a,
    input  wire logic [fwvpi_pkg::LP_ENC_W-1:0]       i_enc_b,
    input  wire logic [fwvpi_pkg::LP_ENC_W-1:0]       i_enc_c,
    input  wire logic [fwvpi_pkg::LP_ENC_W-1:0]       i_enc_d,
    input  wire logic [fwvpi_pkg::LP_ENC_W-1:0]       i_goal_a,
    input  wire logic [fwvpi_pkg::LP_ENC_W-1:0]       i_goal_b,
    input  wire logic [fwvpi_pkg::LP_ENC_W-1:0]       i_goal_c,
    input  wire logic [fwvpi_pkg::LP_ENC_W-1:0]       i_goal_d,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic      [fwvpi_pkg::LP_DUTY_W-1:0]      o_duty_a,
    output logic      [fwvpi_pkg::LP_DUTY_W-1:0]      o_duty_b,
    output logic      [fwvpi_pkg::LP_DUTY_W-1:0]      o_duty_c,
    output logic      [fwvpi_pkg::LP_DUTY_W-1:0]      o_duty_d,
    output logic                                      o_fwd_a,
    output logic                                      o_fwd_b,
    output logic                                      o_fwd_c,
    output logic                                      o_fwd_d
);
    import fwvpi_pkg::*;

    logic [LP_GAIN_W-1:0]  r_prop_gain;
    logic [LP_GAIN_W-1:0]  r_integ_gain;
    logic                  r_polarity;

    logic                  r_busy;
    logic [LP_WHEEL_W-1:0] r_wheel;
    logic [LP_ENC_W-1:0]   r_enc  [LP_WHEELS];
    logic [LP_ENC_W-1:0]   r_goal [LP_WHEELS];
    logic [LP_WHEELS-1:0]  r_ent_vld;

    t_stage                r_s1;
    logic                  r_s1_init;
    logic [LP_ENC_W-1:0]   r_s1_enc;
    logic [LP_ENC_W-1:0]   r_s1_goal;

    logic [LP_DUTY_W-1:0]  r_col_duty [LP_WHEELS];
    logic                  r_col_fwd  [LP_WHEELS];
    logic                  r_out_vld;
    logic [LP_DUTY_W-1:0]  r_duty [LP_WHEELS];
    logic                  r_fwd  [LP_WHEELS];

    logic [LP_ST_W-1:0]    w_rdata;
    t_wr                   w_wr;
    t_lane                 w_lane;
    logic                  w_stall;
    logic                  w_adv;
    logic                  w_issue;
    logic                  w_last_issue;
    logic                  w_in_xfer;
    logic                  w_done;

    assign w_done       = w_lane.vld && w_lane.last;
    assign w_stall      = w_done && r_out_vld && !i_out_ready;
    assign w_adv        = !w_stall;
    assign w_issue      = r_busy && w_adv;
    assign w_last_issue = r_busy && (r_wheel == LP_WHEEL_W'(LP_WHEELS - 1));
    assign o_in_ready   = w_adv && (!r_busy || w_last_issue);
    assign w_in_xfer    = i_in_valid && o_in_ready;
    assign o_cfg_ready  = 1'b1;

    fwvpi_ram #(
        .P_WIDTH (LP_ST_W),
        .P_DEPTH (LP_WHEELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_issue),
        .i_raddr (r_wheel),
        .o_rdata (w_rdata)
    );

    fwvpi_update u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_s1         (r_s1),
        .i_init       (r_s1_init),
        .i_enc        (r_s1_enc),
        .i_goal       (r_s1_goal),
        .i_rdata      (w_rdata),
        .i_prop_gain  (r_prop_gain),
        .i_integ_gain (r_integ_gain),
        .i_polarity   (r_polarity),
        .o_wr         (w_wr),
        .o_lane       (w_lane)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= LP_GAIN_W'(LP_GAIN_RST);
            r_integ_gain <= LP_GAIN_W'(LP_GAIN_RST);
            r_polarity   <= 1'b0;
            r_busy       <= 1'b0;
            r_wheel      <= '0;
            r_ent_vld    <= '0;
            r_s1         <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                    CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                    CFG_POLARITY:   r_polarity   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_adv) begin
                r_s1.vld   <= w_issue;
                r_s1.last  <= w_last_issue;
                r_s1.wheel <= r_wheel;
            end
            if (w_in_xfer) begin
                r_busy  <= 1'b1;
                r_wheel <= '0;
            end else if (w_issue) begin
                r_wheel <= r_wheel + 1'b1;
                if (w_last_issue) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_wr.we) begin
                r_ent_vld[w_wr.addr] <= 1'b1;
            end
            if (w_done && w_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_enc[0]  <= i_enc_a;
            r_enc[1]  <= i_enc_b;
            r_enc[2]  <= i_enc_c;
            r_enc[3]  <= i_enc_d;
            r_goal[0] <= i_goal_a;
            r_goal[1] <= i_goal_b;
            r_goal[2] <= i_goal_c;
            r_goal[3] <= i_goal_d;
        end
        if (w_issue) begin
            r_s1_init <= r_ent_vld[r_wheel];
            r_s1_enc  <= r_enc[r_wheel];
            r_s1_goal <= r_goal[r_wheel];
        end
        if (w_lane.vld && w_adv) begin
            r_col_duty[w_lane.wheel] <= w_lane.duty;
            r_col_fwd[w_lane.wheel]  <= w_lane.fwd;
        end
        if (w_done && w_adv) begin
            for (int i = 0; i < LP_WHEELS; i++) begin
                if (w_lane.wheel == LP_WHEEL_W'(i)) begin
                    r_duty[i] <= w_lane.duty;
                    r_fwd[i]  <= w_lane.fwd;
                end else begin
                    r_duty[i] <= r_col_duty[i];
                    r_fwd[i]  <= r_col_fwd[i];
                end
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_duty_a    = r_duty[0];
    assign o_duty_b    = r_duty[1];
    assign o_duty_c    = r_duty[2];
    assign o_duty_d    = r_duty[3];
    assign o_fwd_a     = r_fwd[0];
    assign o_fwd_b     = r_fwd[1];
    assign o_fwd_c     = r_fwd[2];
    assign o_fwd_d     = r_fwd[3];

endmodule
`default_nettype wire

FILE: src/fwvpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fwvpi_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]         i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: src/fwvpi_update.sv
// Per-wheel PI update: multiply stage, then accumulate, saturate and write back.
`default_nettype none
module fwvpi_update (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_adv,
    input  wire fwvpi_pkg::t_stage                    i_s1,
    input  wire logic                                 i_init,
    input  wire logic [fwvpi_pkg::LP_ENC_W-1:0]       i_enc,
    input  wire logic [fwvpi_pkg::LP_ENC_W-1:0]       i_goal,
    input  wire logic [fwvpi_pkg::LP_ST_W-1:0]        i_rdata,
    input  wire logic [fwvpi_pkg::LP_GAIN_W-1:0]      i_prop_gain,
    input  wire logic [fwvpi_pkg::LP_GAIN_W-1:0]      i_integ_gain,
    input  wire logic                                 i_polarity,
    output fwvpi_pkg::t_wr                            o_wr,
    output fwvpi_pkg::t_lane                          o_lane
);
    import fwvpi_pkg::*;

    localparam int LP_E_W  = LP_ENC_W + 1;
    localparam int LP_D_W  = LP_ERR_W + 1;
    localparam int LP_PP_W = LP_GAIN_W + 1 + LP_D_W;
    localparam int LP_IP_W = LP_GAIN_W + 1 + LP_E_W;
    localparam int LP_S_W  = LP_PP_W + 1;

    logic signed [LP_ERR_W-1:0] w_prev;
    logic signed [LP_ACC_W-1:0] w_acc_old;
    logic signed [LP_E_W-1:0]   w_err;
    logic signed [LP_D_W-1:0]   w_delta;
    logic signed [LP_PP_W-1:0]  w_pp;
    logic signed [LP_IP_W-1:0]  w_ip;

    t_stage                     r_s2;
    logic signed [LP_PP_W-1:0]  r_pp;
    logic signed [LP_IP_W-1:0]  r_ip;
    logic signed [LP_ACC_W-1:0] r_acc;
    logic signed [LP_E_W-1:0]   r_err;

    logic signed [LP_S_W-1:0]   w_sum;
    logic signed [LP_ACC_W-1:0] w_acc_new;
    logic signed [LP_ACC_W-1:0] w_drive;
    logic [LP_DUTY_W-1:0]       w_duty;

    assign w_prev    = i_init ? $signed(i_rdata[LP_ERR_W-1:0]) : '0;
    assign w_acc_old = i_init ? $signed(i_rdata[LP_ST_W-1:LP_ERR_W]) : '0;
    assign w_err     = $signed({i_enc[LP_ENC_W-1], i_enc})
                     - $signed({i_goal[LP_ENC_W-1], i_goal});
    assign w_delta   = $signed({{(LP_D_W-LP_E_W){w_err[LP_E_W-1]}}, w_err})
                     - $signed({w_prev[LP_ERR_W-1], w_prev});
    assign w_pp      = $signed({1'b0, i_prop_gain}) * w_delta;
    assign w_ip      = $signed({1'b0, i_integ_gain}) * w_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else if (i_adv) begin
            r_s2 <= i_s1;
        end
        if (i_adv) begin
            r_pp  <= w_pp;
            r_ip  <= w_ip;
            r_acc <= w_acc_old;
            r_err <= w_err;
        end
    end

    always_comb begin
        w_sum = LP_S_W'(r_pp) + LP_S_W'(r_ip) + LP_S_W'(r_acc);
        if (w_sum > LP_S_W'(LP_ACC_LIM)) begin
            w_acc_new = LP_ACC_W'(LP_ACC_LIM);
        end else if (w_sum < -LP_S_W'(LP_ACC_LIM)) begin
            w_acc_new = -LP_ACC_W'(LP_ACC_LIM);
        end else begin
            w_acc_new = LP_ACC_W'(w_sum);
        end
        if (w_acc_new > LP_ACC_W'(LP_DUTY_LIM)) begin
            w_drive = LP_ACC_W'(LP_DUTY_LIM);
        end else if (w_acc_new < -LP_ACC_W'(LP_DUTY_LIM)) begin
            w_drive = -LP_ACC_W'(LP_DUTY_LIM);
        end else begin
            w_drive = w_acc_new;
        end
        if (w_drive[LP_ACC_W-1]) begin
            w_duty = LP_DUTY_W'(-w_drive);
        end else begin
            w_duty = LP_DUTY_W'(w_drive);
        end
    end

    assign o_wr.we   = r_s2.vld && i_adv;
    assign o_wr.addr = r_s2.wheel;
    assign o_wr.data = {w_acc_new, LP_ERR_W'(r_err)};

    assign o_lane.vld   = r_s2.vld;
    assign o_lane.last  = r_s2.last;
    assign o_lane.wheel = r_s2.wheel;
    assign o_lane.duty  = w_duty;
    assign o_lane.fwd   = ~w_drive[LP_ACC_W-1] ^ i_polarity;

endmodule
`default_nettype wire

FILE: src/fwvpi_checker.sv
// Port-level checker for the four-wheel velocity PI core, bound to the top level.
`default_nettype none
module fwvpi_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_in_valid,
    input wire logic                                 o_in_ready,
    input wire logic                                 o_out_valid,
    input wire logic                                 i_out_ready,
    input wire logic [fwvpi_pkg::LP_DUTY_W-1:0]      o_duty_a,
    input wire logic [fwvpi_pkg::LP_DUTY_W-1:0]      o_duty_b,
    input wire logic [fwvpi_pkg::LP_DUTY_W-1:0]      o_duty_c,
    input wire logic [fwvpi_pkg::LP_DUTY_W-1:0]      o_duty_d,
    input wire logic                                 o_fwd_a,
    input wire logic                                 o_fwd_b,
    input wire logic                                 o_fwd_c,
    input wire logic                                 o_fwd_d
);
    import fwvpi_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_duty_a) && $stable(o_duty_b)
            && $stable(o_duty_c) && $stable(o_duty_d) && $stable(o_fwd_a)
            && $stable(o_fwd_b) && $stable(o_fwd_c) && $stable(o_fwd_d))
        else $error("result changed while stalled");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_duty_a <= LP_DUTY_W'(LP_DUTY_LIM)
            && o_duty_b <= LP_DUTY_W'(LP_DUTY_LIM)
            && o_duty_c <= LP_DUTY_W'(LP_DUTY_LIM)
            && o_duty_d <= LP_DUTY_W'(LP_DUTY_LIM))
        else $error("duty above clamp limit");

endmodule

bind four_wheel_velocity_pi_core fwvpi_checker u_fwvpi_checker (.*);
`default_nettype wire
